### design/fbe_pkg.sv
// fbe_pkg: shared types, constants and the byte mixing function for the
// feistel block encryption pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbe_pkg;

  localparam int BLOCK_W  = 64;
  localparam int BYTE_W   = 8;
  localparam int MAX_BYTES = BLOCK_W / BYTE_W;

  localparam logic [BYTE_W-1:0] MIX_CONST  = 8'hD5;
  localparam int                KEY_SHIFT  = 3;

  typedef logic [BLOCK_W-1:0] half_t;

  typedef struct packed {
    half_t l;
    half_t r;
  } half_pair_t;

  // round function on one byte of the right half and its key byte
  function automatic logic [BYTE_W-1:0] mix_byte(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] k);
    logic [BYTE_W-1:0] t;
    t = a ^ (k & a) ^ MIX_CONST;
    t = t & (k >> KEY_SHIFT);
    t = t ^ a;
    return t | k;
  endfunction

  // mask of the low n bytes of a half
  function automatic half_t half_mask(input int n);
    half_t m;
    m = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (i < n) m[BYTE_W*i +: BYTE_W] = '1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### design/feistel_block_encrypt.sv
// feistel_block_encrypt: a pipeline of registered feistel round stages; one
// block enters per cycle while in_ready is high, so throughput is one block
// per cycle when the output does not stall, set by one round per pipeline stage.
// A stalled output holds the last stage; free stages upstream keep filling.
// Synchronous reset clears all stage valid bits and sets the master key to 0.
// Depends on fbe_pkg and fbe_round.
`timescale 1ns / 1ps
`default_nettype none

module feistel_block_encrypt import fbe_pkg::*; #(
  parameter int HALF_BYTES = 8,
  parameter int KEY_BYTES  = 8,
  parameter int ROUNDS     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               master_key_we,
  input  wire logic [BLOCK_W-1:0] master_key_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BLOCK_W-1:0] left_half,
  input  wire logic [BLOCK_W-1:0] right_half,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BLOCK_W-1:0]      cipher_left,
  output logic [BLOCK_W-1:0]      cipher_right
);

  localparam half_t HALF_MASK = half_mask(HALF_BYTES);

  half_t      master_key;
  half_pair_t stage_data  [ROUNDS+1];
  logic       stage_valid [ROUNDS+1];
  logic       stage_ready [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      master_key <= '0;
    end else if (master_key_we) begin
      master_key <= master_key_wdata;
    end
  end

  // bytes beyond the half width are dropped on entry
  assign stage_data[0].l = left_half & HALF_MASK;
  assign stage_data[0].r = right_half & HALF_MASK;
  assign stage_valid[0]  = in_valid;
  assign in_ready        = stage_ready[0];

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    fbe_round #(
      .ROUND_IDX  (r),
      .HALF_BYTES (HALF_BYTES),
      .KEY_BYTES  (KEY_BYTES)
    ) u_round (
      .clk        (clk),
      .rst        (rst),
      .master_key (master_key),
      .up_valid   (stage_valid[r]),
      .up_ready   (stage_ready[r]),
      .up_data    (stage_data[r]),
      .dn_valid   (stage_valid[r+1]),
      .dn_ready   (stage_ready[r+1]),
      .dn_data    (stage_data[r+1])
    );
  end

  // final swap of the halves
  assign stage_ready[ROUNDS] = out_ready;
  assign out_valid           = stage_valid[ROUNDS];
  assign cipher_left         = stage_data[ROUNDS].r;
  assign cipher_right        = stage_data[ROUNDS].l;

endmodule

`default_nettype wire

### design/fbe_round.sv
// fbe_round: one feistel round as one registered pipeline stage with
// valid/ready flow control. Depends on fbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbe_round import fbe_pkg::*; #(
  parameter int ROUND_IDX  = 0,
  parameter int HALF_BYTES = 8,
  parameter int KEY_BYTES  = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire half_t      master_key,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire half_pair_t up_data,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output half_pair_t      dn_data
);

  half_t      f;
  half_pair_t result;
  logic       valid;
  half_pair_t data;

  for (genvar i = 0; i < MAX_BYTES; i++) begin : g_byte
    if (i < HALF_BYTES) begin : g_used
      // round key is the master key rotated by the round number in bytes
      localparam int KI = ((i % KEY_BYTES) + (ROUND_IDX % KEY_BYTES)) % KEY_BYTES;
      assign f[BYTE_W*i +: BYTE_W] = mix_byte(up_data.r[BYTE_W*i +: BYTE_W],
                                              master_key[BYTE_W*KI +: BYTE_W]);
    end else begin : g_unused
      assign f[BYTE_W*i +: BYTE_W] = '0;
    end
  end

  assign result.l = up_data.r;
  assign result.r = up_data.l ^ f;

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= result;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

`default_nettype wire

### design/fbe_checker.sv
// fbe_checker: port-level assertions for feistel_block_encrypt, attached by
// bind. Depends on fbe_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

module fbe_checker import fbe_pkg::*; #(
  parameter int HALF_BYTES = 8
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [BLOCK_W-1:0] cipher_left,
  input wire logic [BLOCK_W-1:0] cipher_right
);

  localparam half_t HALF_MASK = half_mask(HALF_BYTES);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_left) && $stable(cipher_right))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a taken output frees every stage, so input must be ready
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input not ready while output drains");

  // bytes beyond the half width stay zero
  a_short_half: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((cipher_left & ~HALF_MASK) == '0) && ((cipher_right & ~HALF_MASK) == '0))
    else $error("unused result bytes not zero");

endmodule

bind feistel_block_encrypt fbe_checker #(.HALF_BYTES(HALF_BYTES)) u_fbe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cipher_left  (cipher_left),
  .cipher_right (cipher_right)
);

`default_nettype wire
